@@ rtl/core/jds_pkg.sv @@
// Package for the joint double exponential smoother.
// Holds the sequencer state codes, config register indexes and unit status type.
`default_nettype none
package jds_pkg;

  localparam int NUM_CFG   = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXDEV = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP   = 3'd6;

  // busy while iterating, done for one cycle when the result is ready
  typedef struct packed {
    logic busy;
    logic done;
  } jds_unit_st_t;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_D1   = 21'h000002,
    S_SQ   = 21'h000004,
    S_SUM  = 21'h000008,
    S_RT   = 21'h000010,
    S_STG  = 21'h000020,
    S_S1B  = 21'h000040,
    S_DV1  = 21'h000080,
    S_J    = 21'h000100,
    S_JB   = 21'h000200,
    S_F    = 21'h000400,
    S_FB   = 21'h000800,
    S_TR   = 21'h001000,
    S_TRB  = 21'h002000,
    S_PRED = 21'h004000,
    S_PB   = 21'h008000,
    S_D2   = 21'h010000,
    S_DV2  = 21'h020000,
    S_Q    = 21'h040000,
    S_QB   = 21'h080000,
    S_FIN  = 21'h100000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/jds_if.sv @@
// Request channel interfaces of the joint smoother: raw sample in, result out.
// Standalone; widths follow the PW parameter.
`default_nettype none
interface jds_in_if #(parameter int PW = 20);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [PW-1:0] pos_z;
  logic                 inferred;
  modport source (output valid, pos_x, pos_y, pos_z, inferred, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, inferred, output ready);
endinterface

interface jds_out_if #(parameter int PW = 20);
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] filt_x;
  logic signed [PW-1:0] filt_y;
  logic signed [PW-1:0] filt_z;
  logic signed [PW-1:0] pred_x;
  logic signed [PW-1:0] pred_y;
  logic signed [PW-1:0] pred_z;
  modport source (output valid, filt_x, filt_y, filt_z, pred_x, pred_y, pred_z,
                  input ready);
  modport sink   (input valid, filt_x, filt_y, filt_z, pred_x, pred_y, pred_z,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/jds_lane.sv @@
// One axis lane: registered multiply of a signed value by a Q factor with
// half-away rounding, or a square of the shifted magnitude. No dependencies.
`default_nettype none
module jds_lane #(
  parameter int AW   = 22,
  parameter int FW   = 17,
  parameter int MSW  = 22,
  parameter int KW   = 1,
  parameter int FRAC = 16
) (
  input  wire logic                 clk,
  input  wire logic                 sq,
  input  wire logic [KW-1:0]        k,
  input  wire logic signed [AW-1:0] a,
  input  wire logic [FW-1:0]        f,
  output logic signed [AW-1:0]      res,
  output logic [2*MSW-1:0]          sqr
);
  localparam int OBW = (AW > FW) ? AW : FW;
  localparam int PRW = AW + OBW;

  logic [AW-1:0]  mag;
  logic [AW-1:0]  opa;
  logic [OBW-1:0] opb;
  logic [PRW-1:0] prod_r;
  logic           neg_r;
  logic [PRW-1:0] rnd;
  logic [AW-1:0]  rmag;

  always_comb begin
    mag = a[AW-1] ? (~a + 1'b1) : a;
    opa = sq ? (mag >> k) : mag;
    opb = sq ? OBW'(opa) : OBW'(f);
  end

  always_ff @(posedge clk) begin
    prod_r <= PRW'(opa) * PRW'(opb);
    neg_r  <= a[AW-1] & ~sq;
  end

  always_comb begin
    rnd  = (prod_r + PRW'(64'd1 << (FRAC-1))) >> FRAC;
    rmag = rnd[AW-1:0];
    res  = neg_r ? -$signed(rmag) : $signed(rmag);
    sqr  = prod_r[2*MSW-1:0];
  end
endmodule
`default_nettype wire

@@ rtl/core/jds_sqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
// Depends on jds_pkg for the unit status type.
`default_nettype none
module jds_sqrt import jds_pkg::*; #(
  parameter int SW = 46
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [SW-1:0] x,
  output logic [SW/2-1:0]    root,
  output jds_unit_st_t       st
);
  localparam int RW = SW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [SW-1:0]   x_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+3:0]   rem2;
  logic [RW+3:0]   trial;
  logic            ge;

  always_comb begin
    rem2  = {rem_r, x_r[SW-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    ge    = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
        x_r    <= x;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r    <= x_r << 2;
        rem_r  <= ge ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root    = root_r;
  assign st.busy = busy_r;
  assign st.done = done_r;
endmodule
`default_nettype wire

@@ rtl/core/jds_div.sv @@
// Restoring divider for Q ratios: floor((n << QW-1) / d), one bit per cycle.
// Caller guarantees the quotient fits QW bits. Depends on jds_pkg.
`default_nettype none
module jds_div import jds_pkg::*; #(
  parameter int DVW = 23,
  parameter int QW  = 17
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] n,
  input  wire logic [DVW-1:0] d,
  output logic [QW-1:0]       q,
  output jds_unit_st_t        st
);
  localparam int CW = $clog2(QW + 1);

  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] d_r;
  logic [QW-1:0]  q_r;
  logic           nb_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [DVW:0]   rem2;
  logic           ge;

  always_comb begin
    rem2 = {rem_r, nb_r};
    ge   = rem2 >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
        rem_r  <= n >> 1;   // below d, so the quotient has only QW bits
        nb_r   <= n[0];
        d_r    <= d;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? DVW'(rem2 - {1'b0, d_r}) : DVW'(rem2);
        nb_r  <= 1'b0;
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q       = q_r;
  assign st.busy = busy_r;
  assign st.done = done_r;
endmodule
`default_nettype wire

@@ rtl/core/joint_double_exponential_smoother.sv @@
// Joint double exponential smoother: three axis lanes, shared sqrt and divider.
// Each sample runs two square-root passes, sequencing states and up to two
// divisions (jitter ratio, deviation clamp) between accept and result valid.
// A new sample is accepted only after the last result is loaded into the output
// register; a held result adds stalls.
// Reset (synchronous, rst_n low): config to defaults, filter history cleared.
`default_nettype none
module joint_double_exponential_smoother import jds_pkg::*; #(
  parameter int POS_WIDTH = 20,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  jds_in_if.sink                    in_ch,
  jds_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [((FRAC_BITS+2 > POS_WIDTH-1) ? FRAC_BITS+2 : POS_WIDTH-1)-1:0]
                                    cfg_wdata
);
  localparam int PW   = POS_WIDTH;
  localparam int FRAC = FRAC_BITS;
  localparam int FW   = FRAC + 1;
  localparam int WW   = FRAC + 2;
  localparam int JW   = PW - 1;
  localparam int AW   = PW + 2;
  localparam int MSW  = (AW < 31) ? AW : 31;
  localparam int KMAX = AW - MSW;
  localparam int KW   = $clog2(KMAX + 2);
  localparam int SW   = 2 * MSW + 2;
  localparam int RW   = SW / 2;
  localparam int LENW = AW + 1;
  localparam int DVW  = (LENW > FW) ? LENW : FW;
  localparam int EPW  = FW + WW;

  localparam logic [FW-1:0] ONE_Q     = FW'(64'd1 << FRAC);
  localparam logic [FW-1:0] HALF_Q    = FW'(64'd1 << (FRAC-1));
  localparam logic [WW-1:0] SCALE_INF = WW'(((64'd6 << FRAC) + 64'd2) / 64'd5);
  localparam logic signed [AW:0] SAT_HI = (AW+1)'((64'd1 << (PW-1)) - 64'd1);
  localparam logic signed [AW:0] SAT_LO = -SAT_HI - 1;

  function automatic logic signed [PW-1:0] sat(input logic signed [AW:0] v);
    if (v > SAT_HI) return PW'(SAT_HI);
    if (v < SAT_LO) return PW'(SAT_LO);
    return PW'(v);
  endfunction

  function automatic logic [FW-1:0] cap1(input logic [FW-1:0] v);
    return (v > ONE_Q) ? ONE_Q : v;
  endfunction

  function automatic logic [FW-1:0] eff(input logic [EPW-1:0] prod);
    logic [EPW-1:0] v;
    v = (prod + EPW'(HALF_Q)) >> FRAC;
    return (v > EPW'(ONE_Q)) ? ONE_Q : FW'(v);
  endfunction

  // config registers
  logic [FW-1:0] smooth_r, corr_r, predf_r, jit_r, mdev_r;
  logic [WW-1:0] weight_r;
  logic [JW-1:0] jump_r;

  state_t state_r;
  logic signed [PW-1:0] raw_r [3];
  logic signed [PW-1:0] lraw_r [3];
  logic signed [PW-1:0] lf_r [3];
  logic signed [PW-1:0] lt_r [3];
  logic signed [PW-1:0] f_r [3];
  logic signed [PW-1:0] t_r [3];
  logic signed [AW-1:0] vec_r [3];
  logic signed [AW-1:0] j_r [3];
  logic signed [AW-1:0] p_r [3];
  logic [1:0]     stage_r, stg_r;
  logic           inf_r, phase_r;
  logic [EPW-1:0] pjr_r, pmd_r;
  logic [FW-1:0]  jr_r, md_r, ratio_r;
  logic [LENW-1:0] len_r;
  logic           ov_r;
  logic signed [PW-1:0] of_r [3];
  logic signed [PW-1:0] op_r [3];

  logic signed [AW-1:0] lane_a [3];
  logic signed [AW-1:0] lane_res [3];
  logic [2*MSW-1:0]     lane_sqr [3];
  logic [FW-1:0]        lane_f;
  logic                 lane_sq;
  logic [AW-1:0]        ormag;
  logic [KW-1:0]        k_c;
  logic [SW-1:0]        sum_c;
  logic [RW-1:0]        root;
  logic [LENW-1:0]      len_c;
  logic                 sq_start, dv_start;
  logic [DVW-1:0]       dv_n, dv_d;
  logic [FW-1:0]        dv_q;
  jds_unit_st_t         sq_st, dv_st;
  logic [WW-1:0]        scale;
  logic                 jit_ok, raw_zero;

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_lane
      jds_lane #(.AW(AW), .FW(FW), .MSW(MSW), .KW(KW), .FRAC(FRAC)) u_lane (
        .clk (clk), .sq (lane_sq), .k (k_c), .a (lane_a[gi]), .f (lane_f),
        .res (lane_res[gi]), .sqr (lane_sqr[gi])
      );
    end
  endgenerate

  jds_sqrt #(.SW(SW)) u_sqrt (
    .clk (clk), .rst_n (rst_n), .start (sq_start), .x (sum_c), .root (root), .st (sq_st)
  );

  jds_div #(.DVW(DVW), .QW(FW)) u_div (
    .clk (clk), .rst_n (rst_n), .start (dv_start), .n (dv_n), .d (dv_d),
    .q (dv_q), .st (dv_st)
  );

  // shift that keeps every shifted magnitude below 2^MSW, its square below 2^(2*MSW)
  always_comb begin
    ormag = '0;
    for (int i = 0; i < 3; i++)
      ormag = ormag | (vec_r[i][AW-1] ? (~vec_r[i] + 1'b1) : vec_r[i]);
    k_c = '0;
    for (int q = KMAX; q >= 0; q--)
      if ((((AW+1)'(ormag) >> q) >> MSW) == '0) k_c = KW'(q);
  end

  always_comb begin
    sum_c = SW'(lane_sqr[0]) + SW'(lane_sqr[1]) + SW'(lane_sqr[2]);
    len_c = LENW'(root) << k_c;
    scale = inf_r ? SCALE_INF : weight_r;
    raw_zero = (raw_r[0] == '0) && (raw_r[1] == '0) && (raw_r[2] == '0);
    jit_ok = (DVW'(len_r) <= DVW'(jr_r)) && (jr_r != '0);
  end

  always_comb begin
    lane_sq = 1'b0;
    lane_f  = '0;
    for (int i = 0; i < 3; i++) lane_a[i] = '0;
    case (state_r)
      S_SQ: begin
        lane_sq = 1'b1;
        for (int i = 0; i < 3; i++) lane_a[i] = vec_r[i];
      end
      S_STG: begin
        lane_f = HALF_Q;
        for (int i = 0; i < 3; i++) lane_a[i] = AW'(raw_r[i]) + AW'(lraw_r[i]);
      end
      S_J: begin
        lane_f = ratio_r;
        for (int i = 0; i < 3; i++) lane_a[i] = AW'(raw_r[i]) - AW'(lf_r[i]);
      end
      S_F: begin
        lane_f = cap1(smooth_r);
        for (int i = 0; i < 3; i++) lane_a[i] = AW'(lf_r[i]) + AW'(lt_r[i]) - j_r[i];
      end
      S_TR: begin
        lane_f = cap1(corr_r);
        for (int i = 0; i < 3; i++)
          lane_a[i] = AW'(f_r[i]) - AW'(lf_r[i]) - AW'(lt_r[i]);
      end
      S_PRED: begin
        lane_f = cap1(predf_r);
        for (int i = 0; i < 3; i++) lane_a[i] = AW'(t_r[i]);
      end
      S_Q: begin
        lane_f = ratio_r;
        for (int i = 0; i < 3; i++) lane_a[i] = vec_r[i];
      end
      default: begin
        lane_sq = 1'b0;
      end
    endcase
  end

  assign sq_start = (state_r == S_SUM);
  assign dv_start = ((state_r == S_STG) && (stg_r != 2'd0) && (stg_r != 2'd1) && jit_ok)
                 || ((state_r == S_RT) && phase_r && sq_st.done
                     && (DVW'(len_c) > DVW'(md_r)));
  assign dv_n = phase_r ? DVW'(md_r) : DVW'(len_r);
  assign dv_d = phase_r ? DVW'(len_c) : DVW'(jr_r);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.filt_x = of_r[0];
  assign out_ch.filt_y = of_r[1];
  assign out_ch.filt_z = of_r[2];
  assign out_ch.pred_x = op_r[0];
  assign out_ch.pred_y = op_r[1];
  assign out_ch.pred_z = op_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= FW'(64'd1 << (FRAC-1));
      corr_r   <= FW'(64'd1 << (FRAC-2));
      predf_r  <= FW'(64'd1 << (FRAC-1));
      jit_r    <= FW'(((64'd5 << FRAC) + 64'd50) / 64'd100);
      mdev_r   <= FW'(((64'd5 << FRAC) + 64'd50) / 64'd100);
      weight_r <= WW'(64'd1 << FRAC);
      jump_r   <= JW'(((64'd2 << FRAC) + 64'd5) / 64'd10);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SMOOTH: smooth_r <= cfg_wdata[FW-1:0];
        CFG_CORR:   corr_r   <= cfg_wdata[FW-1:0];
        CFG_PRED:   predf_r  <= cfg_wdata[FW-1:0];
        CFG_JITTER: jit_r    <= cfg_wdata[FW-1:0];
        CFG_MAXDEV: mdev_r   <= cfg_wdata[FW-1:0];
        CFG_WEIGHT: weight_r <= cfg_wdata[WW-1:0];
        CFG_JUMP:   jump_r   <= cfg_wdata[JW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= 2'd0;
      ov_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lraw_r[i] <= '0;
        lf_r[i]   <= '0;
        lt_r[i]   <= '0;
      end
    end else begin
      if (state_r == S_FIN && (!ov_r || out_ch.ready)) ov_r <= 1'b1;
      else if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            raw_r[0] <= in_ch.pos_x;
            raw_r[1] <= in_ch.pos_y;
            raw_r[2] <= in_ch.pos_z;
            inf_r    <= in_ch.inferred;
            phase_r  <= 1'b0;
            state_r  <= S_D1;
          end
        end
        S_D1: begin
          pjr_r <= EPW'(jit_r) * EPW'(scale);
          pmd_r <= EPW'(mdev_r) * EPW'(scale);
          for (int i = 0; i < 3; i++) vec_r[i] <= AW'(raw_r[i]) - AW'(lf_r[i]);
          state_r <= S_SQ;
        end
        S_SQ: begin
          jr_r    <= eff(pjr_r);
          md_r    <= eff(pmd_r);
          state_r <= S_SUM;
        end
        S_SUM: state_r <= S_RT;
        S_RT: begin
          if (sq_st.done) begin
            if (!phase_r) begin
              // a snap leaves a zero distance for the jitter test
              if (len_c > LENW'(jump_r)) begin
                for (int i = 0; i < 3; i++) lf_r[i] <= raw_r[i];
                len_r <= '0;
              end else begin
                len_r <= len_c;
              end
              stg_r   <= raw_zero ? 2'd0 : stage_r;
              state_r <= S_STG;
            end else begin
              state_r <= (DVW'(len_c) > DVW'(md_r)) ? S_DV2 : S_FIN;
            end
          end
        end
        S_STG: begin
          case (stg_r)
            2'd0: begin
              for (int i = 0; i < 3; i++) begin
                f_r[i] <= raw_r[i];
                t_r[i] <= '0;
              end
              state_r <= S_PRED;
            end
            2'd1: state_r <= S_S1B;
            default: begin
              if (jit_ok) begin
                state_r <= S_DV1;
              end else begin
                for (int i = 0; i < 3; i++) j_r[i] <= AW'(raw_r[i]);
                state_r <= S_F;
              end
            end
          endcase
        end
        S_S1B: begin
          for (int i = 0; i < 3; i++) f_r[i] <= sat((AW+1)'(lane_res[i]));
          state_r <= S_TR;
        end
        S_DV1: begin
          if (dv_st.done) begin
            ratio_r <= dv_q;
            state_r <= S_J;
          end
        end
        S_J:  state_r <= S_JB;
        S_JB: begin
          for (int i = 0; i < 3; i++) j_r[i] <= AW'(lf_r[i]) + lane_res[i];
          state_r <= S_F;
        end
        S_F:  state_r <= S_FB;
        S_FB: begin
          for (int i = 0; i < 3; i++)
            f_r[i] <= sat((AW+1)'(j_r[i]) + (AW+1)'(lane_res[i]));
          state_r <= S_TR;
        end
        S_TR:  state_r <= S_TRB;
        S_TRB: begin
          for (int i = 0; i < 3; i++)
            t_r[i] <= sat((AW+1)'(lt_r[i]) + (AW+1)'(lane_res[i]));
          state_r <= S_PRED;
        end
        S_PRED: state_r <= S_PB;
        S_PB: begin
          for (int i = 0; i < 3; i++) p_r[i] <= AW'(f_r[i]) + lane_res[i];
          state_r <= S_D2;
        end
        S_D2: begin
          for (int i = 0; i < 3; i++) vec_r[i] <= p_r[i] - AW'(raw_r[i]);
          phase_r <= 1'b1;
          state_r <= S_SQ;
        end
        S_DV2: begin
          if (dv_st.done) begin
            ratio_r <= dv_q;
            state_r <= S_Q;
          end
        end
        S_Q:  state_r <= S_QB;
        S_QB: begin
          for (int i = 0; i < 3; i++) p_r[i] <= AW'(raw_r[i]) + lane_res[i];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!ov_r || out_ch.ready) begin
            for (int i = 0; i < 3; i++) begin
              of_r[i]   <= f_r[i];
              op_r[i]   <= sat((AW+1)'(p_r[i]));
              lraw_r[i] <= raw_r[i];
              lf_r[i]   <= f_r[i];
              lt_r[i]   <= t_r[i];
            end
            stage_r <= (stg_r == 2'd0) ? 2'd1 : 2'd2;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !(ov_r && !out_ch.ready)) |=> (ov_r && state_r == S_IDLE))
    else $error("finished sample not loaded into output register");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dv_start |-> !dv_st.busy)
    else $error("divider restarted while busy");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (!sq_st.busy && !dv_st.busy))
    else $error("request accepted while a shared unit is busy");
  a_stage_code: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r != 2'd3)
    else $error("frame stage reached unused code");
`endif

endmodule
`default_nettype wire
